// ----- sv/itoa_pkg.sv -----
// itoa_pkg: shared types and constants for the signed integer to decimal text block.
// Used by the channel interfaces, the conversion stage and the top level.
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int VALUE_W        = 32;
  localparam int CHAR_W         = 8;
  localparam int DIG_W          = 4;
  localparam int NDIG           = 10;
  localparam int IDX_W          = 4;
  localparam int BITS_PER_STAGE = 4;
  localparam int NSTAGE         = VALUE_W / BITS_PER_STAGE;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

  typedef logic [NDIG-1:0][DIG_W-1:0] bcd_t;

  // Payload carried down the conversion pipeline.
  typedef struct packed {
    logic               neg;
    bcd_t               bcd;
    logic [VALUE_W-1:0] bin;
  } dab_t;

  // Index of the most significant nonzero digit; zero when all digits are zero.
  function automatic logic [IDX_W-1:0] lead_idx(input bcd_t b);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (b[i] != '0) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- sv/itoa_if.sv -----
// itoa_if: valid/ready channel interfaces for the integer input and the text output.
// Depends on itoa_pkg for field widths.
`timescale 1ns / 1ps

interface itoa_in_if import itoa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itoa_out_if import itoa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- sv/itoa_dabble.sv -----
// itoa_dabble: one registered shift-and-add-3 stage of the binary to BCD conversion.
// Depends on itoa_pkg for the stage payload type.
`timescale 1ns / 1ps

module itoa_dabble import itoa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  dab_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output dab_t out_data
);

  logic valid_r;
  dab_t data_r;
  dab_t data_nxt;

  // Consume BITS_PER_STAGE magnitude bits, most significant first.
  always_comb begin
    data_nxt = in_data;
    for (int b = 0; b < BITS_PER_STAGE; b++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (data_nxt.bcd[d] >= DIG_W'(5)) begin
          data_nxt.bcd[d] = data_nxt.bcd[d] + DIG_W'(3);
        end
      end
      {data_nxt.bcd, data_nxt.bin} = {data_nxt.bcd, data_nxt.bin} << 1;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- sv/signed_int_to_decimal_ascii.sv -----
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text, top level.
// Depends on itoa_pkg, the channel interfaces in itoa_if and the itoa_dabble stage.
// Usage:
//   in_if  (sink)   : one beat carries one signed 32-bit value.
//   out_if (source) : one beat carries one ASCII character; last marks the final
//                     character of a number. A negative value starts with '-',
//                     leading zeros are dropped, zero gives "0", and the most
//                     negative value gives all eleven characters "-2147483648".
//   Path: a number passes the sign register, loaded at the input edge, then eight
//   conversion stages, the serializer and the output register, where its first
//   character is shown.
//   Throughput: one character per cycle while out_if.ready is high; the serializer
//   sets that rate. Numbers follow each other on the output with no gap in
//   between, and up to nine more inputs stand in the sign and conversion stages
//   meanwhile.
//   Reset (rst_n low, synchronous): all valid bits clear; no beat is pending.
//   Stall: while out_if.ready is low the output register holds its beat, the
//   serializer holds, and the pipeline fills up stage by stage before in_if.ready
//   drops. Nothing is lost or repeated.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii import itoa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  itoa_in_if.sink    in_if,
  itoa_out_if.source out_if
);

  // ---------------------------------------------------------------------------
  // Sign stage: split off the sign and form the magnitude in unsigned math,
  // which covers the most negative value without overflow.
  // ---------------------------------------------------------------------------
  logic s0_valid_r;
  dab_t s0_data_r;
  dab_t s0_data_nxt;
  logic s0_ready;

  logic [NSTAGE:0] st_valid;
  logic [NSTAGE:0] st_ready;
  dab_t            st_data [NSTAGE+1];

  always_comb begin
    s0_data_nxt.neg = in_if.value[VALUE_W-1];
    s0_data_nxt.bcd = '0;
    s0_data_nxt.bin = in_if.value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_if.value))
                                             : VALUE_W'(in_if.value);
  end

  assign s0_ready    = !s0_valid_r || st_ready[0];
  assign in_if.ready = s0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && in_if.valid) begin
      s0_data_r <= s0_data_nxt;
    end
  end

  assign st_valid[0] = s0_valid_r;
  assign st_data[0]  = s0_data_r;

  // ---------------------------------------------------------------------------
  // Conversion pipeline: each stage shifts four magnitude bits into the BCD digits.
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < NSTAGE; g++) begin : g_dab
    itoa_dabble u_dab (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (st_valid[g]),
      .in_ready  (st_ready[g]),
      .in_data   (st_data[g]),
      .out_valid (st_valid[g+1]),
      .out_ready (st_ready[g+1]),
      .out_data  (st_data[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Serializer: walk the digits from the leading nonzero one down, sign first.
  // ---------------------------------------------------------------------------
  logic             ser_busy_r;
  logic             ser_neg_r;
  logic [IDX_W-1:0] ser_idx_r;
  bcd_t             ser_bcd_r;

  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  logic              out_load;
  logic              ser_done;
  logic              ser_take;
  logic [CHAR_W-1:0] out_char_nxt;
  logic              out_last_nxt;

  assign out_load = ser_busy_r && (!out_valid_r || out_if.ready);
  assign ser_done = out_load && !ser_neg_r && (ser_idx_r == '0);
  assign ser_take = !ser_busy_r || ser_done;
  assign st_ready[NSTAGE] = ser_take;

  always_comb begin
    if (ser_neg_r) begin
      out_char_nxt = CH_MINUS;
      out_last_nxt = 1'b0;
    end else begin
      out_char_nxt = CH_ZERO + CHAR_W'(ser_bcd_r[ser_idx_r]);
      out_last_nxt = (ser_idx_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_busy_r <= 1'b0;
    end else if (ser_take) begin
      ser_busy_r <= st_valid[NSTAGE];
    end
  end

  // Load a fresh number, or advance: drop the sign, then count the digit down.
  always_ff @(posedge clk) begin
    if (ser_take && st_valid[NSTAGE]) begin
      ser_neg_r <= st_data[NSTAGE].neg;
      ser_idx_r <= lead_idx(st_data[NSTAGE].bcd);
      ser_bcd_r <= st_data[NSTAGE].bcd;
    end else if (out_load) begin
      if (ser_neg_r) begin
        ser_neg_r <= 1'b0;
      end else if (ser_idx_r != '0) begin
        ser_idx_r <= ser_idx_r - IDX_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold the beat until the receiver takes it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char_r <= out_char_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.character = out_char_r;
  assign out_if.last      = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    ser_busy_r |-> (ser_idx_r < IDX_W'(NDIG)))
    else $error("serializer digit index out of range");

  a_digit_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !ser_neg_r) |-> (ser_bcd_r[ser_idx_r] <= DIG_W'(9)))
    else $error("non-decimal digit reached the serializer");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_char_r == CH_MINUS)) |-> !out_last_r)
    else $error("sign character marked as last");

  a_in_to_s0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> s0_valid_r)
    else $error("accepted input beat not captured by sign stage");

  a_take_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    ser_done |=> (out_valid_r && out_last_r))
    else $error("final character not presented with last set");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for signed_int_to_decimal_ascii (integer in, ASCII text out).
// Depends on itoa_pkg, the channel interfaces in itoa_if and the top-level RTL.

module tb;
  import itoa_pkg::*;

  // Bench limits; the first three are in clock cycles.
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off, fills the pipeline
  localparam int DRAIN_CYCLES   = 40;    // settle time after the last character
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either channel
  localparam int RANDOM_VALUES  = 350;
  localparam int MAX_PRINTED    = 50;    // mismatches printed before going quiet
  localparam int N_DIR          = 22;

  // One expected character of the output text, with the number it belongs to.
  typedef struct packed {
    logic [CHAR_W-1:0]  character;
    logic               last;
    logic [VALUE_W-1:0] value;
  } text_beat_t;

  // Shapes of random values.
  typedef enum int {VK_ANY, VK_DIGITS, VK_DECADE, VK_EDGE, VK_TINY} val_kind_e;

  // Receiver ready patterns.
  typedef enum int {RX_OPEN, RX_PERIODIC, RX_COIN, RX_MOSTLY} rx_mode_e;

  logic clk;
  logic rst_n;

  itoa_in_if  in_ch ();
  itoa_out_if out_ch ();

  signed_int_to_decimal_ascii u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  text_beat_t  text_q [$];     // characters still owed by the block, oldest first
  int unsigned err_count  = 0;
  int unsigned vals_sent  = 0;  // input beats accepted so far
  int unsigned burst_left = 0;  // input beats left in the current sender burst
  int unsigned quiet_cycles = 0;

  // Directed table. A text entry is the exact expected output, read off at a
  // glance; an empty entry means the row is checked through the predictor.
  logic [VALUE_W-1:0] dir_value [N_DIR] = '{
    32'd0,          32'd1,          -32'sd1,        32'd9,
    -32'sd9,        32'd10,         -32'sd10,       32'd99,
    32'd100,        32'h7FFF_FFFF,  32'h8000_0000,  32'h8000_0001,
    32'd1000000000, -32'sd1000000000, 32'd999999999, 32'd1234567890,
    -32'sd123456789, 32'h5555_5555, 32'hAAAA_AAAA,  32'h7FFF_FFFE,
    32'd4096,       -32'sd65536
  };
  string dir_text [N_DIR] = '{
    "0",            "1",            "-1",           "9",
    "-9",           "10",           "-10",          "",
    "",             "2147483647",   "-2147483648",  "-2147483647",
    "1000000000",   "-1000000000",  "999999999",    "",
    "",             "",             "",             "",
    "",             ""
  };

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Queue up the decimal text of one value: optional '-', then the digits of
  // the magnitude, most significant first, with last on the final digit. The
  // magnitude is taken in unsigned 32-bit arithmetic, so the most negative
  // value comes out whole.
  function automatic void push_decimal_text(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [DIG_W-1:0]   dig [NDIG];
    int                 n;
    mag = v[VALUE_W-1] ? (32'd0 - v) : v;
    n = 0;
    do begin
      dig[n] = DIG_W'(mag % 32'd10);
      mag    = mag / 32'd10;
      n++;
    end while (mag != 0 && n < NDIG);
    if (v[VALUE_W-1]) begin
      text_q.push_back(text_beat_t'{CH_MINUS, 1'b0, v});
    end
    for (int i = n - 1; i >= 0; i--) begin
      text_q.push_back(text_beat_t'{CH_ZERO + CHAR_W'(dig[i]), (i == 0), v});
    end
  endfunction

  // Draw a random value. Most draws pick a digit count first so that every
  // text length shows up often; the rest are raw 32-bit words, powers of ten
  // and their neighbors, values near both extremes, and tiny numbers.
  function automatic logic [VALUE_W-1:0] pick_value();
    val_kind_e          kind;
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] decade;
    int unsigned        ndig;
    kind   = ($urandom_range(0, 2) == 0) ? val_kind_e'($urandom_range(0, 4)) : VK_DIGITS;
    ndig   = $urandom_range(1, 9);
    decade = 32'd1;
    repeat (ndig) decade = decade * 32'd10;
    case (kind)
      VK_ANY:    v = $urandom();
      VK_DECADE: v = decade - $urandom_range(0, 1);
      VK_EDGE:   v = $urandom_range(0, 1) ? (32'h8000_0000 + $urandom_range(0, 3))
                                          : (32'h7FFF_FFFF - $urandom_range(0, 3));
      VK_TINY:   v = $urandom_range(0, 20);
      default:   v = $urandom_range(decade - 1, 0);
    endcase
    if (kind != VK_ANY && kind != VK_EDGE && $urandom_range(0, 1) == 1) begin
      v = 32'd0 - v;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTED) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    err_count++;
  endtask

  // Offer one value and hold it until the block takes it. On acceptance,
  // record what the block owes, then either keep valid up for the next beat
  // of the burst or drop it for a random gap.
  task automatic send_value(input logic [VALUE_W-1:0] v, input string txt);
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    if (txt.len() == 0) begin
      push_decimal_text(v);
    end else begin
      for (int i = 0; i < txt.len(); i++) begin
        text_q.push_back(text_beat_t'{CHAR_W'(txt[i]), (i == txt.len() - 1), v});
      end
    end
    vals_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // Mostly short bursts, now and then a long unbroken one.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      gap        = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stimulus: reset, directed table, random values, then drain and judge.
  initial begin : stimulus
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      send_value(dir_value[i], dir_text[i]);
    end
    for (int i = 0; i < RANDOM_VALUES; i++) begin
      send_value(pick_value(), "");
    end
    in_ch.valid <= 1'b0;

    // Wait for every owed character, then watch a while for strays.
    while (text_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: ready follows a pattern of its own, switched at random after each
  // run of random length. Once the sender has had 40 beats taken, hold ready low for a
  // long stretch so the pipeline backs up and in ready drops.
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned run;
    int unsigned period;
    int unsigned tick;
    bit          hold_done;
    hold_done    = 1'b0;
    tick         = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!hold_done && vals_sent >= 40) begin
        hold_done    = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode   = rx_mode_e'($urandom_range(0, 3));
      run    = $urandom_range(4, 40);
      period = $urandom_range(2, 6);
      repeat (run) begin
        case (mode)
          RX_OPEN:     out_ch.ready <= 1'b1;
          RX_PERIODIC: out_ch.ready <= (tick % period == 0);
          RX_COIN:     out_ch.ready <= $urandom_range(0, 1);
          default:     out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  // Checker: compare each accepted character with the oldest one owed.
  always @(posedge clk) begin : char_check
    text_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (text_q.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                  out_ch.character, out_ch.last));
      end else begin
        want = text_q.pop_front();
        if (out_ch.character !== want.character) begin
          report_mismatch($sformatf("value %0d: character 0x%02h, expected 0x%02h",
                                    $signed(want.value), out_ch.character, want.character));
        end
        if (out_ch.last !== want.last) begin
          report_mismatch($sformatf("value %0d: last %0b, expected %0b",
                                    $signed(want.value), out_ch.last, want.last));
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[%0t] TIMEOUT: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
